>>> rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Operation and status codes, field widths and the command that the
// controller broadcasts to the row of list cells.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Fixed field widths of the item channels.
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;

    // Operation codes carried in an input item.
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    // Status codes returned in a result item.
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // What the cells do in one cycle.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_ROTATE = 2'd3
    } act_t;

    // Command broadcast to every cell: action, 0-based slot and list length.
    typedef struct packed {
        act_t             act;
        logic [CNT_W-1:0] slot;
        logic [CNT_W-1:0] len;
    } cell_cmd_t;

endpackage

>>> rtl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit: bounded ordered list of signed 32-bit values
// Top level joining the operation controller to a row of shift cells.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one operation per item: insert at front, back or
// a 1-based position, delete at front, back or a position, or dump. The
// master channel returns the results with status and count after the
// operation; tlast marks the final result of each operation.
// Every operation except dump gives one result, registered in the cycle after
// the item is accepted; a new item is taken every cycle while results drain,
// since inserts and deletes shift all cells in parallel.
// Dump gives one result per element, front to back (one empty result when
// the list is empty); the row rotates by one cell for each result, so the
// head cell is read and the list is back in order at the end. No item
// is accepted during a dump.
// A stalled receiver holds the result register, and tready on the slave
// side drops until that register can take a new result.
// Reset clears the length and the pending result; cell contents are left
// as they are and are never read before being written.
// ----------------------------------------------------------------------------
module positional_list_engine_unit
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // op[2:0], value[34:3], position[41:35], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[1:0], count[8:2], element[40:9], zero fill
    output logic        m_tlast
);

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    cell_cmd_t                 cmd;
    logic [STAT_W-1:0]         out_status;
    logic [CNT_W-1:0]          out_count;
    logic signed [VALUE_W-1:0] out_element;
    logic [OP_W-1:0]           in_op;
    logic signed [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]          in_position;

    // Unpack the input item.
    assign in_op       = s_tdata[OP_W-1:0];
    assign in_value    = s_tdata[OP_W+VALUE_W-1:OP_W];
    assign in_position = s_tdata[OP_W+VALUE_W+POS_W-1:OP_W+VALUE_W];

    // Operation controller and result register.
    ple_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_op       (in_op),
        .in_position (in_position),
        .head_value  (cell_value[0]),
        .cmd         (cmd),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_status  (out_status),
        .out_count   (out_count),
        .out_element (out_element),
        .out_last    (m_tlast)
    );

    // Row of cells, each wired to its neighbours and to the head.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] left_v;
        logic signed [VALUE_W-1:0] right_v;

        if (i == 0) begin : g_first
            assign left_v = in_value;
        end else begin : g_inner_l
            assign left_v = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_v = cell_value[i];
        end else begin : g_inner_r
            assign right_v = cell_value[i+1];
        end

        ple_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .in_value    (in_value),
            .left_value  (left_v),
            .right_value (right_v),
            .head_value  (cell_value[0]),
            .value_out   (cell_value[i])
        );
    end

    // Pack the result item.
    assign m_tdata = {7'd0, out_element, out_count, out_status};

endmodule

>>> rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list row
// Holds one element and, from the broadcast command and its own position,
// keeps it, loads the new value, or takes a neighbour's or the head's element.
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic                      aclk,
    input  cell_cmd_t                 cmd,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic signed [VALUE_W-1:0] right_value,
    input  logic signed [VALUE_W-1:0] head_value,
    output logic signed [VALUE_W-1:0] value_out
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // Choose the source of this cell's element for the next cycle.
    always_comb begin
        value_next = value_reg;
        unique case (cmd.act)
            ACT_INSERT: begin
                if (IDX > cmd.slot) begin
                    value_next = left_value;
                end else if (IDX == cmd.slot) begin
                    value_next = in_value;
                end
            end
            ACT_DELETE: begin
                if (IDX >= cmd.slot) begin
                    value_next = right_value;
                end
            end
            ACT_ROTATE: begin
                // Rotation stays within the occupied cells, the tail taking the head.
                if ((IDX + 1'b1) < cmd.len) begin
                    value_next = right_value;
                end else if ((IDX + 1'b1) == cmd.len) begin
                    value_next = head_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    // Element storage; payload only, so no reset.
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;

endmodule

>>> rtl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl: operation decoder and result sequencer
// Checks each operation against the length, drives the cell command,
// keeps the length and steps through the list during a dump.
// ----------------------------------------------------------------------------
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [OP_W-1:0]           in_op,
    input  logic [POS_W-1:0]          in_position,
    input  logic signed [VALUE_W-1:0] head_value,
    output cell_cmd_t                 cmd,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [STAT_W-1:0]         out_status,
    output logic [CNT_W-1:0]          out_count,
    output logic signed [VALUE_W-1:0] out_element,
    output logic                      out_last
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          length_reg, length_next;
    logic [LEN_W-1:0]          dump_cnt_reg, dump_cnt_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0]         status_reg, status_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [VALUE_W-1:0] element_reg, element_next;
    logic                      last_reg, last_next;

    logic             slot_free;
    logic             accept;
    logic             emit;
    logic [CNT_W-1:0] len_ext;
    logic [CNT_W:0]   pos_w;
    logic [CNT_W:0]   len_w;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign len_ext   = CNT_W'(length_reg);
    assign pos_w     = {1'b0, CNT_W'(in_position)};
    assign len_w     = {1'b0, len_ext};

    // Decode the accepted item, or take the next dump step.
    always_comb begin
        state_next    = state_reg;
        length_next   = length_reg;
        dump_cnt_next = dump_cnt_reg;
        cmd           = '{act: ACT_NONE, slot: '0, len: len_ext};
        emit          = 1'b0;
        status_next   = ST_OK;
        element_next  = '0;
        last_next     = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    emit = 1'b1;
                    unique case (in_op)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                            if (in_op == OP_INS_AT &&
                                (pos_w == '0 || pos_w > (len_w + 1'b1))) begin
                                status_next = ST_BADPOS;
                            end else if (length_reg >= CAP_LEN) begin
                                status_next = ST_FULL;
                            end else begin
                                cmd.act = ACT_INSERT;
                                if (in_op == OP_INS_FRONT) begin
                                    cmd.slot = '0;
                                end else if (in_op == OP_INS_BACK) begin
                                    cmd.slot = len_ext;
                                end else begin
                                    cmd.slot = CNT_W'(in_position) - 1'b1;
                                end
                                length_next = length_reg + 1'b1;
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                            if (length_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else if (in_op == OP_DEL_AT &&
                                         (pos_w == '0 || pos_w > len_w)) begin
                                status_next = ST_BADPOS;
                            end else begin
                                cmd.act = ACT_DELETE;
                                if (in_op == OP_DEL_FRONT) begin
                                    cmd.slot = '0;
                                end else if (in_op == OP_DEL_BACK) begin
                                    cmd.slot = len_ext - 1'b1;
                                end else begin
                                    cmd.slot = CNT_W'(in_position) - 1'b1;
                                end
                                length_next = length_reg - 1'b1;
                            end
                        end
                        OP_DUMP: begin
                            if (length_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                // First element goes out now; the row rotates by one.
                                cmd.act       = ACT_ROTATE;
                                element_next  = head_value;
                                last_next     = (length_reg == LEN_W'(1));
                                dump_cnt_next = LEN_W'(1);
                                if (length_reg != LEN_W'(1)) begin
                                    state_next = S_DUMP;
                                end
                            end
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (slot_free) begin
                    emit          = 1'b1;
                    cmd.act       = ACT_ROTATE;
                    element_next  = head_value;
                    last_next     = (dump_cnt_reg == (length_reg - 1'b1));
                    dump_cnt_next = dump_cnt_reg + 1'b1;
                    if (dump_cnt_reg == (length_reg - 1'b1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        count_next = CNT_W'(length_next);

        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // State, length and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            length_reg   <= '0;
            dump_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            length_reg   <= length_next;
            dump_cnt_reg <= dump_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (emit) begin
            status_reg  <= status_next;
            count_reg   <= count_next;
            element_reg <= element_next;
            last_reg    <= last_next;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign out_status  = status_reg;
    assign out_count   = count_reg;
    assign out_element = element_reg;
    assign out_last    = last_reg;

endmodule

>>> rtl/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker: port-level checks of the positional list engine
// Watches the item channels of the top level and flags sequencing errors.
// ----------------------------------------------------------------------------
module ple_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result holds its value.
    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast));
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    // An item is only taken when the result register can receive its answer.
    property p_room;
        @(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready);
    endproperty
    a_room: assert property (p_room) else $error("item taken with result register full");

    // Within a dump no new item is taken before its final result.
    property p_dump_busy;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready;
    endproperty
    a_dump_busy: assert property (p_dump_busy) else $error("item taken during a dump");

    // Intermediate dump results are always good, and the count stays in bounds.
    property p_result_sane;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tlast || m_tdata[1:0] == ST_OK) &&
                      (m_tdata[8:2] <= CNT_W'(CAPACITY)));
    endproperty
    a_result_sane: assert property (p_result_sane) else $error("malformed result");

endmodule

bind positional_list_engine_unit ple_checker #(
    .CAPACITY(CAPACITY)
) u_ple_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> dv/positional_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb: self-checking bench for the list engine
// Drives list operations on the slave stream with random gaps, keeps a
// software copy of the list and compares every result item on the master
// stream, field by field, against the value that the copy predicts.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;
    import ple_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 200;

    // Kinds of random phase: balanced, biased towards filling, biased
    // towards emptying.
    localparam int MIX_PHASE    = 0;
    localparam int GROW_PHASE   = 1;
    localparam int SHRINK_PHASE = 2;

    // The opcode that the block leaves unused.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [CNT_W-1:0]   count;
        logic [VALUE_W-1:0] element;
        logic               last;
    } list_result_t;

    // Software copy of the list and the queue of results still awaited.
    class list_mirror;
        logic [VALUE_W-1:0] cells [DEPTH];
        int unsigned        len;
        list_result_t       awaited [$];
        int unsigned        errors;

        function new();
            len    = 0;
            errors = 0;
        endfunction

        function void push(status_t st, logic [VALUE_W-1:0] el, logic lst);
            list_result_t r;
            r.status  = st;
            r.count   = len[CNT_W-1:0];
            r.element = el;
            r.last    = lst;
            awaited.push_back(r);
        endfunction

        // Apply one accepted operation and queue the results it causes.
        function void take_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                              logic [POS_W-1:0] pos);
            int unsigned idx;
            int unsigned i;
            case (op)
                OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                    // A bad position is reported ahead of a full list.
                    if (op == OP_INS_AT && (pos < 1 || pos > len + 1)) begin
                        push(ST_BADPOS, '0, 1'b1);
                    end else if (len >= DEPTH) begin
                        push(ST_FULL, '0, 1'b1);
                    end else begin
                        if (op == OP_INS_FRONT)
                            idx = 0;
                        else if (op == OP_INS_BACK)
                            idx = len;
                        else
                            idx = pos - 1;
                        for (i = len; i > idx; i--)
                            cells[i] = cells[i-1];
                        cells[idx] = value;
                        len++;
                        push(ST_OK, '0, 1'b1);
                    end
                end
                OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                    if (len == 0) begin
                        push(ST_EMPTY, '0, 1'b1);
                    end else if (op == OP_DEL_AT && (pos < 1 || pos > len)) begin
                        push(ST_BADPOS, '0, 1'b1);
                    end else begin
                        if (op == OP_DEL_FRONT)
                            idx = 0;
                        else if (op == OP_DEL_BACK)
                            idx = len - 1;
                        else
                            idx = pos - 1;
                        for (i = idx; i + 1 < len; i++)
                            cells[i] = cells[i+1];
                        len--;
                        push(ST_OK, '0, 1'b1);
                    end
                end
                OP_DUMP: begin
                    if (len == 0) begin
                        push(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (i = 0; i < len; i++)
                            push(ST_OK, cells[i], (i + 1 == len));
                    end
                end
                default: begin
                    // The unused opcode changes nothing and reports the count.
                    push(ST_OK, '0, 1'b1);
                end
            endcase
        endfunction

        // Compare one accepted result item with the oldest one awaited.
        function void match_result(logic [47:0] data, logic lst);
            list_result_t got;
            list_result_t want;
            got.status  = data[1:0];
            got.count   = data[8:2];
            got.element = data[40:9];
            got.last    = lst;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, status %0d count %0d element %0h last %0b",
                         $time, got.status, got.count, got.element, got.last);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: count mismatch, expected %0d, actual %0d",
                         $time, want.count, got.count);
                errors++;
            end
            if (got.element !== want.element) begin
                $display("%0t: element mismatch, expected %0h, actual %0h",
                         $time, want.element, got.element);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    list_mirror  mirror = new();
    bit          no_idle = 1'b0;
    int unsigned random_sent = 0;
    int unsigned cycles = 0;

    positional_list_engine_unit #(
        .CAPACITY (DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run-length guard.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("positional_list_engine_unit_tb failed");
            $finish;
        end
    end

    // Check every result item accepted on the master side.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            mirror.match_result(m_tdata, m_tlast);
    end

    // Receiver: a random stall before each result item, none in calm phases.
    initial begin
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Present one item after a random gap and wait until it is taken.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pos, value, op};
        do @(posedge aclk); while (!s_tready);
        mirror.take_op(op, value, pos);
    endtask

    // Hold the sender off until every awaited result has arrived.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (mirror.awaited.size() != 0)
            @(posedge aclk);
    endtask

    // One random item; the phase kind sets the mix of inserts and deletes.
    task automatic send_random(input int kind);
        int unsigned        r;
        int unsigned        k;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        int unsigned        ins_cut;
        int unsigned        del_cut;
        int unsigned        dump_cut;
        if (kind == GROW_PHASE) begin
            ins_cut = 75; del_cut = 90; dump_cut = 98;
        end else if (kind == SHRINK_PHASE) begin
            ins_cut = 20; del_cut = 88; dump_cut = 96;
        end else begin
            ins_cut = 45; del_cut = 85; dump_cut = 97;
        end
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 2);
        if (r < ins_cut)
            op = (k == 0) ? OP_INS_FRONT : (k == 1) ? OP_INS_BACK : OP_INS_AT;
        else if (r < del_cut)
            op = (k == 0) ? OP_DEL_FRONT : (k == 1) ? OP_DEL_BACK : OP_DEL_AT;
        else if (r < dump_cut)
            op = OP_DUMP;
        else
            op = OP_UNUSED;

        // Mostly legal positions, with some zero and some anywhere.
        r = $urandom_range(0, 9);
        if (r == 0)
            pos = POS_W'($urandom_range(0, 127));
        else if (r == 1)
            pos = '0;
        else if (op == OP_DEL_AT)
            pos = (mirror.len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, mirror.len));
        else
            pos = POS_W'($urandom_range(1, mirror.len + 1));

        r = $urandom_range(0, 9);
        if (r == 0)
            value = 32'h8000_0000;
        else if (r == 1)
            value = 32'h7fff_ffff;
        else
            value = $urandom;

        send_op(op, value, pos);
        random_sent++;
    endtask

    // Run one phase; grow and shrink phases linger a few items at the limit.
    task automatic run_phase(input int kind);
        int unsigned n;
        int unsigned tail;
        n    = 0;
        tail = 0;
        while (tail < 4 && n < 80 && random_sent < RANDOM_ITEMS) begin
            send_random(kind);
            n++;
            if (kind == MIX_PHASE) begin
                if (n >= 20)
                    tail = 4;
            end else if ((kind == GROW_PHASE && mirror.len == DEPTH) ||
                         (kind == SHRINK_PHASE && mirror.len == 0)) begin
                tail++;
            end
        end
    endtask

    // Main sequence: reset, directed items, random phases, then wind-down.
    initial begin
        int unsigned phase;
        int          kind;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty list: dump, every delete, bad insert positions.
        send_op(OP_DUMP,      32'd0,        7'd0);
        send_op(OP_DEL_FRONT, 32'd1,        7'd0);
        send_op(OP_DEL_BACK,  32'd2,        7'd0);
        send_op(OP_DEL_AT,    32'd3,        7'd0);
        send_op(OP_DEL_AT,    32'd4,        7'd127);
        send_op(OP_INS_AT,    32'd5,        7'd0);
        send_op(OP_INS_AT,    32'd6,        7'd2);
        // Build a short list with the extreme values.
        send_op(OP_INS_AT,    32'h8000_0000, 7'd1);
        send_op(OP_INS_FRONT, 32'h7fff_ffff, 7'd0);
        send_op(OP_INS_BACK,  32'h0000_0000, 7'd0);
        send_op(OP_INS_BACK,  32'hffff_ffff, 7'd127);
        send_op(OP_INS_AT,    32'h0000_0005, 7'd3);
        send_op(OP_INS_AT,    32'h1234_5678, 7'd6);
        send_op(OP_INS_AT,    32'h0bad_0bad, 7'd127);
        // Bad and good delete positions, the unused opcode and a dump.
        send_op(OP_DEL_AT,    32'd0,        7'd0);
        send_op(OP_DEL_AT,    32'd0,        7'd7);
        send_op(OP_DEL_AT,    32'd0,        7'd3);
        send_op(OP_DEL_AT,    32'd0,        7'd5);
        send_op(OP_UNUSED,    32'hffff_ffff, 7'd127);
        send_op(OP_DUMP,      32'd0,        7'd0);
        send_op(OP_DEL_FRONT, 32'd0,        7'd0);
        send_op(OP_DEL_BACK,  32'd0,        7'd0);
        drain();

        // Random phases: fill first, then empty, then a random choice.
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase == 0)
                kind = GROW_PHASE;
            else if (phase == 1)
                kind = SHRINK_PHASE;
            else
                kind = $urandom_range(MIX_PHASE, SHRINK_PHASE);
            no_idle = ($urandom_range(0, 3) == 0);
            run_phase(kind);
            if (phase == 1 || $urandom_range(0, 2) == 0)
                drain();
            phase++;
        end

        drain();
        no_idle = 1'b0;
        repeat (20) @(posedge aclk);
        if (mirror.errors == 0)
            $display("positional_list_engine_unit_tb passed");
        else
            $display("positional_list_engine_unit_tb failed");
        $finish;
    end

endmodule

>>> files.f
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine_unit.sv
rtl/ple_checker.sv
dv/positional_list_engine_unit_tb.sv
